### rtl/core/bis_pkg.sv
// shared types and constants for the bilinear image scaler
// no dependencies
package bis_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int STEP_W  = 24;
  localparam int DST_W   = 12;
  localparam int POS_W   = STEP_W + DST_W;
  localparam int FRAC_W  = 16;
  localparam int INT_W   = POS_W - FRAC_W;
  localparam int WGT_W   = FRAC_W + 1;
  localparam int PIX_W   = 32;
  localparam int CH_W    = 8;
  localparam int NCH     = 4;
  localparam int PROD_W  = CH_W + WGT_W;
  localparam int SUM_W   = PROD_W + 2;

  // register addresses
  localparam logic REG_X_STEP = 1'b0;
  localparam logic REG_Y_STEP = 1'b1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // parity of the four neighbour coordinates, picks the bank per neighbour
  typedef struct packed {
    logic x0;
    logic x1;
    logic y0;
    logic y1;
  } nb_sel_t;

endpackage

### rtl/core/bis_step.sv
// source position, neighbour clamping and bilinear weights
// depends on bis_pkg
module bis_step #(
  parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
  parameter int CW = $clog2(MAX_WIDTH),
  parameter int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [bis_pkg::DST_W-1:0]    dst_col,
  input  logic [bis_pkg::DST_W-1:0]    dst_row,
  input  logic [bis_pkg::STEP_W-1:0]   x_step,
  input  logic [bis_pkg::STEP_W-1:0]   y_step,
  output logic [CW-1:0]                x0,
  output logic [CW-1:0]                x1,
  output logic [RW-1:0]                y0,
  output logic [RW-1:0]                y1,
  output logic [bis_pkg::WGT_W-1:0]    w1,
  output logic [bis_pkg::WGT_W-1:0]    w2,
  output logic [bis_pkg::WGT_W-1:0]    w3,
  output logic [bis_pkg::WGT_W-1:0]    w4,
  output bis_pkg::nb_sel_t             sel
);
  import bis_pkg::*;

  logic [POS_W-1:0]   px;
  logic [POS_W-1:0]   py;
  logic [INT_W-1:0]   ix;
  logic [INT_W-1:0]   iy;
  logic [INT_W:0]     ix1;
  logic [INT_W:0]     iy1;
  logic [WGT_W-1:0]   fx;
  logic [WGT_W-1:0]   fy;
  logic [WGT_W-1:0]   gx;
  logic [WGT_W-1:0]   gy;
  logic [2*WGT_W-1:0] p1;
  logic [2*WGT_W-1:0] p2;
  logic [2*WGT_W-1:0] p3;
  logic [2*WGT_W-1:0] p4;

  // stage 1: scaled position
  always_ff @(posedge clk) begin
    if (en) begin
      px <= POS_W'(dst_col) * POS_W'(x_step);
      py <= POS_W'(dst_row) * POS_W'(y_step);
    end
  end

  // integer part clamped to the store, fractions kept
  always_comb begin
    ix  = px[POS_W-1:FRAC_W];
    iy  = py[POS_W-1:FRAC_W];
    ix1 = {1'b0, ix} + (INT_W+1)'(1);
    iy1 = {1'b0, iy} + (INT_W+1)'(1);
    x0  = (ix  > INT_W'(MAX_WIDTH - 1))      ? CW'(MAX_WIDTH - 1)  : ix[CW-1:0];
    x1  = (ix1 > (INT_W+1)'(MAX_WIDTH - 1))  ? CW'(MAX_WIDTH - 1)  : ix1[CW-1:0];
    y0  = (iy  > INT_W'(MAX_HEIGHT - 1))     ? RW'(MAX_HEIGHT - 1) : iy[RW-1:0];
    y1  = (iy1 > (INT_W+1)'(MAX_HEIGHT - 1)) ? RW'(MAX_HEIGHT - 1) : iy1[RW-1:0];
    fx  = {1'b0, px[FRAC_W-1:0]};
    fy  = {1'b0, py[FRAC_W-1:0]};
    gx  = WGT_W'(1 << FRAC_W) - fx;
    gy  = WGT_W'(1 << FRAC_W) - fy;
    p1  = (2*WGT_W)'(gx) * (2*WGT_W)'(gy);
    p2  = (2*WGT_W)'(fx) * (2*WGT_W)'(gy);
    p3  = (2*WGT_W)'(gx) * (2*WGT_W)'(fy);
    p4  = (2*WGT_W)'(fx) * (2*WGT_W)'(fy);
  end

  // stage 2: truncated weights and bank selects
  always_ff @(posedge clk) begin
    if (en) begin
      w1     <= p1[FRAC_W +: WGT_W];
      w2     <= p2[FRAC_W +: WGT_W];
      w3     <= p3[FRAC_W +: WGT_W];
      w4     <= p4[FRAC_W +: WGT_W];
      sel.x0 <= x0[0];
      sel.x1 <= x1[0];
      sel.y0 <= y0[0];
      sel.y1 <= y1[0];
    end
  end

endmodule

### rtl/core/bis_store.sv
// source frame store in four banks split by column and row parity
// depends on bis_pkg
module bis_store #(
  parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
  parameter int CW = $clog2(MAX_WIDTH),
  parameter int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      we,
  input  logic [CW-1:0]             wcol,
  input  logic [RW-1:0]             wrow,
  input  logic [bis_pkg::PIX_W-1:0] wdata,
  input  logic [CW-1:0]             x0,
  input  logic [CW-1:0]             x1,
  input  logic [RW-1:0]             y0,
  input  logic [RW-1:0]             y1,
  output logic [bis_pkg::PIX_W-1:0] rdata [4]
);
  import bis_pkg::*;

  localparam int BANK_COLS  = (MAX_WIDTH + 1) / 2;
  localparam int BANK_ROWS  = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [AW-1:0] waddr;
  logic [1:0]    wbank;

  // write address inside the bank
  assign waddr = AW'(int'(wrow >> 1) * BANK_COLS + int'(wcol >> 1));
  assign wbank = {wrow[0], wcol[0]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [BANK_DEPTH];
    logic [CW-1:0]    rcol;
    logic [RW-1:0]    rrow;
    logic [AW-1:0]    raddr;

    // pick the neighbour column and row that fall in this bank
    always_comb begin
      rcol  = (x0[0] == b[0]) ? x0 : x1;
      rrow  = (y0[0] == b[1]) ? y0 : y1;
      raddr = AW'(int'(rrow >> 1) * BANK_COLS + int'(rcol >> 1));
    end

    always_ff @(posedge clk) begin
      if (en && we && (wbank == 2'(b))) begin
        mem[waddr] <= wdata;
      end
      if (en) begin
        rdata[b] <= mem[raddr];
      end
    end
  end

endmodule

### rtl/core/bis_blend.sv
// per channel weighting, sum, truncation and saturation
// depends on bis_pkg
module bis_blend (
  input  logic                      clk,
  input  logic                      en,
  input  logic [bis_pkg::PIX_W-1:0] rdata [4],
  input  bis_pkg::nb_sel_t          sel,
  input  logic [bis_pkg::WGT_W-1:0] w1,
  input  logic [bis_pkg::WGT_W-1:0] w2,
  input  logic [bis_pkg::WGT_W-1:0] w3,
  input  logic [bis_pkg::WGT_W-1:0] w4,
  output logic [bis_pkg::PIX_W-1:0] pixel_out
);
  import bis_pkg::*;

  logic [PIX_W-1:0]  na;
  logic [PIX_W-1:0]  nb;
  logic [PIX_W-1:0]  nc;
  logic [PIX_W-1:0]  nd;
  logic [PROD_W-1:0] pa [NCH];
  logic [PROD_W-1:0] pb [NCH];
  logic [PROD_W-1:0] pc [NCH];
  logic [PROD_W-1:0] pd [NCH];
  logic [PIX_W-1:0]  pix_next;

  // route bank words to neighbours
  assign na = rdata[{sel.y0, sel.x0}];
  assign nb = rdata[{sel.y0, sel.x1}];
  assign nc = rdata[{sel.y1, sel.x0}];
  assign nd = rdata[{sel.y1, sel.x1}];

  // stage 3: sixteen channel products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < NCH; ch++) begin
        pa[ch] <= PROD_W'(na[ch*CH_W +: CH_W]) * PROD_W'(w1);
        pb[ch] <= PROD_W'(nb[ch*CH_W +: CH_W]) * PROD_W'(w2);
        pc[ch] <= PROD_W'(nc[ch*CH_W +: CH_W]) * PROD_W'(w3);
        pd[ch] <= PROD_W'(nd[ch*CH_W +: CH_W]) * PROD_W'(w4);
      end
    end
  end

  // sum, drop the fraction, clip at full scale
  always_comb begin
    logic [SUM_W-1:0] sum;
    logic [SUM_W-FRAC_W-1:0] top;
    pix_next = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      sum = SUM_W'(pa[ch]) + SUM_W'(pb[ch]) + SUM_W'(pc[ch]) + SUM_W'(pd[ch]);
      top = sum[SUM_W-1:FRAC_W];
      pix_next[ch*CH_W +: CH_W] = (top > (SUM_W-FRAC_W)'(8'hff)) ? 8'hff : top[CH_W-1:0];
    end
  end

  // stage 4: output word
  always_ff @(posedge clk) begin
    if (en) begin
      pixel_out <= pix_next;
    end
  end

endmodule

### rtl/core/bilinear_image_scale.sv
// bilinear image scaler top level: stream ports, register port, pipeline control
// depends on bis_pkg, bis_step, bis_store, bis_blend
//
// usage
//   s_* stream takes words: tuser = operation; a write word stores pixel_in at
//   (src_col, src_row), a sample word returns one interpolated pixel on m_*.
//   write words with src_col >= MAX_WIDTH or src_row >= MAX_HEIGHT are dropped.
//   x_step at byte address 0, y_step at 4, both Q16, written while idle.
//   pipeline of four register stages: scaled position, weights and frame
//   store read, channel products, sum and clip; a sample word reaches
//   m_tdata after passing all four in that order. one word per cycle
//   while m_tready keeps the pipeline moving, set by the four-bank frame
//   store that serves all four neighbours at once.
//   a write word is visible to any sample accepted after it.
//   reset clears the valid bits and loads both steps with 1.0; frame store
//   contents stay undefined until written.
//   when m_tready is low with a word waiting, the whole pipeline holds and
//   s_tready drops; bubbles already in the pipeline stay where they are.
module bilinear_image_scale #(
  parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // src_col, src_row, pixel_in, dst_col, dst_row
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bis_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [STEP_W-1:0] x_step;
  logic [STEP_W-1:0] y_step;
  logic              en;
  logic              v1;
  logic              v2;
  logic              v3;
  logic              v4;
  logic              op1;
  logic              wok1;
  logic [CW-1:0]     wcol1;
  logic [RW-1:0]     wrow1;
  logic [PIX_W-1:0]  wpix1;
  logic [12:0]       in_col;
  logic [12:0]       in_row;
  logic [CW-1:0]     x0;
  logic [CW-1:0]     x1;
  logic [RW-1:0]     y0;
  logic [RW-1:0]     y1;
  logic [WGT_W-1:0]  w1;
  logic [WGT_W-1:0]  w2;
  logic [WGT_W-1:0]  w3;
  logic [WGT_W-1:0]  w4;
  nb_sel_t           sel;
  logic [PIX_W-1:0]  rdata [4];

  // register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      x_step <= STEP_W'(1 << FRAC_W);
      y_step <= STEP_W'(1 << FRAC_W);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_X_STEP: x_step <= pwdata[STEP_W-1:0];
        REG_Y_STEP: y_step <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end
  assign prdata = (paddr[2] == REG_Y_STEP) ? 32'(y_step) : 32'(x_step);

  // pipeline advances unless the output word is stuck
  assign en       = !v4 || m_tready;
  assign s_tready = en;
  assign m_tvalid = v4;

  assign in_col = 13'(s_tdata[7:0]);
  assign in_row = 13'(s_tdata[15:8]);

  // valid bits; write words leave the pipe after the store stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1 && (op1 == OP_SAMPLE);
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1 write payload
  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= s_tuser;
      wok1  <= (in_col < 13'(MAX_WIDTH)) && (in_row < 13'(MAX_HEIGHT));
      wcol1 <= in_col[CW-1:0];
      wrow1 <= in_row[RW-1:0];
      wpix1 <= s_tdata[47:16];
    end
  end

  bis_step #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .CW        (CW),
    .RW        (RW)
  ) u_step (
    .clk    (clk),
    .en     (en),
    .dst_col(s_tdata[59:48]),
    .dst_row(s_tdata[71:60]),
    .x_step (x_step),
    .y_step (y_step),
    .x0     (x0),
    .x1     (x1),
    .y0     (y0),
    .y1     (y1),
    .w1     (w1),
    .w2     (w2),
    .w3     (w3),
    .w4     (w4),
    .sel    (sel)
  );

  bis_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .CW        (CW),
    .RW        (RW)
  ) u_store (
    .clk  (clk),
    .en   (en),
    .we   (v1 && (op1 == OP_WRITE) && wok1),
    .wcol (wcol1),
    .wrow (wrow1),
    .wdata(wpix1),
    .x0   (x0),
    .x1   (x1),
    .y0   (y0),
    .y1   (y1),
    .rdata(rdata)
  );

  bis_blend u_blend (
    .clk      (clk),
    .en       (en),
    .rdata    (rdata),
    .sel      (sel),
    .w1       (w1),
    .w2       (w2),
    .w3       (w3),
    .w4       (w4),
    .pixel_out(m_tdata)
  );

endmodule
